// ----- hw/rtl/gafl_pkg.sv -----
// Shared types and constants for the gamepad action frame link.
package gafl_pkg;

	localparam int AXES_DEF       = 10;
	localparam int FULL_SCALE_DEF = 20000;
	localparam int MOUSE_MAX_RST  = 30;

	localparam logic [1:0] KIND_ACTION = 2'd0;
	localparam logic [1:0] KIND_GAME   = 2'd1;
	localparam logic [1:0] KIND_CALIB  = 2'd2;
	localparam logic [1:0] KIND_REPLY  = 2'd3;

	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_MATCHED  = 3'd1;
	localparam logic [2:0] ST_HEART    = 3'd2;
	localparam logic [2:0] ST_SKIPPED  = 3'd3;
	localparam logic [2:0] ST_BROKEN   = 3'd4;

	// operation class decided by the front end
	localparam logic [2:0] OP_PASS   = 3'd0;
	localparam logic [2:0] OP_BUTTON = 3'd1;
	localparam logic [2:0] OP_ABS    = 3'd2;
	localparam logic [2:0] OP_REL    = 3'd3;
	localparam logic [2:0] OP_GWR    = 3'd4;
	localparam logic [2:0] OP_CWR    = 3'd5;
	localparam logic [2:0] OP_REPLY  = 3'd6;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  act;
		logic        axis_ok;
		logic [3:0]  axis;
		logic [15:0] idx;
		logic [7:0]  vbyte;
		logic [14:0] entry;
		logic [7:0]  rx;
	} cmd_t;

endpackage

// ----- hw/rtl/gafl_div.sv -----
// Restoring divider: signed 40-bit dividend by unsigned 10-bit divisor.
module gafl_div import gafl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [39:0] dividend,
	input  logic [9:0]         divisor,
	output logic               done,
	output logic signed [40:0] quotient
);
	logic [39:0] mag_q;
	logic [39:0] quo_q;
	logic [10:0] rem_q;
	logic [9:0]  dsr_q;
	logic        neg_q;
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [10:0] trial;
	logic [10:0] diff;

	assign trial = {rem_q[9:0], mag_q[39]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[39];
			mag_q <= dividend[39] ? 40'(-dividend) : 40'(dividend);
			dsr_q <= (divisor == 10'd0) ? 10'd1 : divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[38:0], 1'b0};
			if (!diff[10]) begin
				rem_q <= diff;
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ----- hw/rtl/gafl_front.sv -----
// Front end: accepts items, classifies them, scales relative motion.
module gafl_front import gafl_pkg::*; #(
	parameter int AXES       = AXES_DEF,
	parameter int FULL_SCALE = FULL_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  action_code,
	input  logic signed [31:0] action_value,
	input  logic [3:0]  table_axis,
	input  logic [14:0] table_index,
	input  logic [14:0] table_entry,
	input  logic [7:0]  rx_byte,
	input  logic [9:0]  mouse_max,
	output logic        q_push,
	output cmd_t        q_data,
	input  logic        q_full
);
	localparam int HALF = FULL_SCALE / 2;

	logic        div_busy_q;
	cmd_t        hold_q;
	logic        div_start;
	logic        div_done;
	logic signed [40:0] quo;
	logic signed [39:0] prod;
	cmd_t        cmd;
	logic        acc;
	logic signed [41:0] ridx;

	assign ready = !q_full && !div_busy_q;
	assign acc   = valid && ready;
	assign prod  = 40'(action_value) * 40'sd100;

	always_comb begin
		cmd        = '0;
		cmd.entry  = table_entry;
		cmd.rx     = rx_byte;
		cmd.act    = action_code;
		cmd.vbyte  = action_value[7:0];
		cmd.idx    = 16'(table_index);
		cmd.axis   = table_axis;
		cmd.axis_ok = (32'(table_axis) < AXES) && (32'(table_index) <= FULL_SCALE);
		unique case (kind)
			KIND_GAME:  cmd.op = OP_GWR;
			KIND_CALIB: cmd.op = OP_CWR;
			KIND_REPLY: cmd.op = OP_REPLY;
			default: begin
				if (action_code >= 8'd10 && action_code < 8'd50) begin
					cmd.op    = OP_BUTTON;
					cmd.act   = action_code + 8'd10;
					cmd.vbyte = {7'd0, action_value != 32'sd0};
				end else if (action_code >= 8'd50 && action_code < 8'd60) begin
					cmd.op   = OP_ABS;
					cmd.act  = action_code - 8'd50;
					cmd.axis = 4'(action_code - 8'd50);
					cmd.axis_ok = 32'(cmd.axis) < AXES;
					if (action_value > 32'(HALF))
						cmd.idx = 16'(FULL_SCALE);
					else if (action_value < -32'(HALF))
						cmd.idx = 16'd0;
					else
						cmd.idx = 16'(action_value + 32'(HALF));
				end else if (action_code >= 8'd100 && action_code < 8'd110) begin
					cmd.op   = OP_REL;
					cmd.act  = action_code - 8'd100;
					cmd.axis = 4'(action_code - 8'd100);
					cmd.axis_ok = 32'(cmd.axis) < AXES;
				end else begin
					cmd.op = OP_PASS;
				end
			end
		endcase
	end

	assign div_start = acc && cmd.op == OP_REL;

	gafl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod),
		.divisor(mouse_max), .done(div_done), .quotient(quo)
	);

	assign ridx = 42'(quo) + 42'sd0 + 42'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_busy_q <= 1'b0;
		else if (div_start)
			div_busy_q <= 1'b1;
		else if (div_done)
			div_busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (div_start)
			hold_q <= cmd;
	end

	always_comb begin
		q_push = 1'b0;
		q_data = cmd;
		if (div_done) begin
			q_push = 1'b1;
			q_data = hold_q;
			if (ridx > 42'sd0 + 42'(FULL_SCALE))
				q_data.idx = 16'(FULL_SCALE);
			else if (ridx < 42'sd0)
				q_data.idx = 16'd0;
			else
				q_data.idx = 16'(ridx);
		end else if (acc && cmd.op != OP_REL) begin
			q_push = 1'b1;
		end
	end
endmodule

// ----- hw/rtl/gafl_fifo.sv -----
// Small command queue between front and back end.
module gafl_fifo import gafl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	output logic empty,
	input  logic pop,
	output cmd_t rdata
);
	cmd_t        mem_q [4];
	logic [2:0]  wp_q, rp_q;

	assign full  = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
	assign empty = wp_q == rp_q;
	assign rdata = mem_q[rp_q[1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 3'd1;
			if (pop && !empty) rp_q <= rp_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q[1:0]] <= wdata;
	end
endmodule

// ----- hw/rtl/gafl_back.sv -----
// Back end: map memories, frame builder and reply checker.
module gafl_back import gafl_pkg::*; #(
	parameter int AXES       = AXES_DEF,
	parameter int FULL_SCALE = FULL_SCALE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       valid,
	input  logic       ready,
	output logic       is_frame,
	output logic [7:0] tx_byte,
	output logic       last,
	output logic [2:0] reply_status
);
	localparam int ROW   = FULL_SCALE + 1;
	localparam int DEPTH = AXES * ROW;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDG  = 3'd1;
	localparam logic [2:0] S_RDC  = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [14:0] game_mem [DEPTH];
	logic [7:0]  calib_mem [DEPTH];

	logic [2:0]  state_q;
	cmd_t        cur_q;
	logic [AW-1:0] base_q;
	logic [14:0] g_rd_q;
	logic [7:0]  c_rd_q;
	logic [7:0]  b0_q, b1_q;
	logic [1:0]  n_q;
	logic [7:0]  exp_q;
	logic [1:0]  phase_q;
	logic [7:0]  skip_q;
	logic        ovld_q;
	logic        ofr_q, olast_q;
	logic [7:0]  otx_q;
	logic [2:0]  ost_q;
	logic [AW-1:0] gaddr, caddr, waddr, abase;
	logic [14:0] gsat;
	logic [7:0]  b2, sum;
	logic        out_free;
	logic        out_load;
	logic [2:0]  rep_st;

	assign out_free = !ovld_q || ready;
	assign valid = ovld_q;
	assign is_frame = ofr_q;
	assign tx_byte = otx_q;
	assign last = olast_q;
	assign reply_status = ost_q;

	assign abase = AW'(32'(q_data.axis) * ROW);
	assign waddr = abase + AW'(q_data.idx);
	assign gsat  = (32'(g_rd_q) > FULL_SCALE) ? 15'(FULL_SCALE) : g_rd_q;
	assign gaddr = base_q + AW'(cur_q.idx);
	assign caddr = base_q + AW'(gsat);
	assign b2    = b0_q ^ b1_q;
	assign sum   = b0_q + b1_q + b2;
	assign q_pop = state_q == S_IDLE && !q_empty && out_free;
	// output register loads on a reply pop or on each frame byte
	assign out_load = (q_pop && q_data.op == OP_REPLY) || (state_q == S_EMIT && out_free);

	// status of the reply byte at the queue head
	always_comb begin
		rep_st = ST_PENDING;
		priority if (phase_q == 2'd1) begin
			if (q_data.rx == 8'd0) rep_st = ST_HEART;
		end else if (phase_q == 2'd2) begin
			if (skip_q <= 8'd1) rep_st = ST_SKIPPED;
		end else begin
			if (q_data.rx == exp_q) rep_st = ST_MATCHED;
			else if (q_data.rx != 8'd0) rep_st = ST_BROKEN;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.op == OP_GWR && q_data.axis_ok)
			game_mem[waddr] <= q_data.entry;
		g_rd_q <= game_mem[gaddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.op == OP_CWR && q_data.axis_ok)
			calib_mem[waddr] <= q_data.entry[7:0];
		c_rd_q <= calib_mem[caddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_data;
			base_q <= abase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exp_q   <= 8'd1;
			phase_q <= 2'd0;
			skip_q  <= 8'd0;
			ovld_q  <= 1'b0;
			n_q     <= 2'd0;
			b0_q    <= '0;
			b1_q    <= '0;
			ofr_q   <= 1'b0;
			olast_q <= 1'b0;
			otx_q   <= '0;
			ost_q   <= '0;
		end else begin
			if (out_load) ovld_q <= 1'b1;
			else if (ready) ovld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_pop) begin
					unique case (q_data.op)
						OP_GWR, OP_CWR: state_q <= S_IDLE;
						OP_REPLY: begin
							ofr_q <= 1'b0; otx_q <= 8'd0; olast_q <= 1'b1;
							ost_q <= rep_st;
							priority if (phase_q == 2'd1) begin
								if (q_data.rx == 8'd0) begin
									phase_q <= 2'd0;
								end else begin
									skip_q <= q_data.rx; phase_q <= 2'd2;
								end
							end else if (phase_q == 2'd2) begin
								if (skip_q <= 8'd1) begin
									skip_q <= 8'd0; phase_q <= 2'd0;
								end else
									skip_q <= skip_q - 8'd1;
							end else begin
								if (q_data.rx != exp_q && q_data.rx == 8'd0) phase_q <= 2'd1;
							end
						end
						OP_ABS, OP_REL: begin
							b0_q <= q_data.act + 8'd1;
							if (q_data.axis_ok) state_q <= S_RDG;
							else begin b1_q <= 8'd0; state_q <= S_EMIT; n_q <= 2'd0; end
						end
						default: begin
							b0_q <= q_data.act + 8'd1;
							b1_q <= q_data.vbyte;
							state_q <= S_EMIT; n_q <= 2'd0;
						end
					endcase
				end
				S_RDG: state_q <= S_WAIT;
				S_WAIT: state_q <= S_RDC;
				S_RDC: begin b1_q <= c_rd_q; state_q <= S_EMIT; n_q <= 2'd0; end
				S_EMIT: if (out_free) begin
					ofr_q <= 1'b1; ost_q <= ST_PENDING;
					olast_q <= n_q == 2'd2;
					otx_q <= (n_q == 2'd0) ? b0_q : (n_q == 2'd1) ? b1_q : b2;
					n_q <= n_q + 2'd1;
					if (n_q == 2'd2) begin
						state_q <= S_IDLE;
						exp_q <= (sum == 8'd0) ? 8'd1 : sum;
						phase_q <= 2'd0; skip_q <= 8'd0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_exp_nz: assert property (@(posedge clk) disable iff (!arst_n) exp_q != 8'd0)
		else $error("expected reply zero");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n) phase_q != 2'd3)
		else $error("bad reply phase");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != S_EMIT || $past(q_data.op) != OP_REPLY)
		else $error("reply entered frame emit");
`endif
endmodule

// ----- hw/rtl/gamepad_action_frame_link_top.sv -----
// Top level of the gamepad action frame link.
// Actions pass the queue to S_EMIT, which sends three bytes through the output register;
// axis lookups first pass S_RDG, S_WAIT and S_RDC. Relative motion adds a 40-step serial
// divide in the front end, with in_ready low meanwhile. Replies: one per cycle if out_ready.
// A 4-entry queue decouples front and back; the back end handles one transaction at a time.
// arst_n clears control state and sets mouse_max to 30; map memories stay undefined.
module gamepad_action_frame_link_top import gafl_pkg::*; #(
	parameter int AXES       = AXES_DEF,
	parameter int FULL_SCALE = FULL_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  action_code,
	input  logic signed [31:0] action_value,
	input  logic [3:0]  table_axis,
	input  logic [14:0] table_index,
	input  logic [14:0] table_entry,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_frame,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [2:0]  reply_status
);
	logic [9:0] mouse_max_q;
	logic       q_push, q_full, q_empty, q_pop;
	cmd_t       q_wdata, q_rdata;

	// single configuration register; the user must write it only when idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mouse_max_q <= 10'(MOUSE_MAX_RST);
		else if (cfg_we)
			mouse_max_q <= cfg_wdata;
	end

	gafl_front #(.AXES(AXES), .FULL_SCALE(FULL_SCALE)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.kind(kind), .action_code(action_code), .action_value(action_value),
		.table_axis(table_axis), .table_index(table_index),
		.table_entry(table_entry), .rx_byte(rx_byte), .mouse_max(mouse_max_q),
		.q_push(q_push), .q_data(q_wdata), .q_full(q_full)
	);

	gafl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata),
		.full(q_full), .empty(q_empty), .pop(q_pop), .rdata(q_rdata)
	);

	gafl_back #(.AXES(AXES), .FULL_SCALE(FULL_SCALE)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_rdata),
		.q_pop(q_pop), .valid(out_valid), .ready(out_ready),
		.is_frame(is_frame), .tx_byte(tx_byte), .last(last),
		.reply_status(reply_status)
	);
endmodule

// ----- sim/tb_gamepad_action_frame_link_top.sv -----
// Testbench for the gamepad action frame link: directed table, map preload, random traffic.
module tb_gamepad_action_frame_link_top import gafl_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAXES   = AXES_DEF;
	localparam int SCALE   = FULL_SCALE_DEF;
	localparam int ROWLEN  = SCALE + 1;
	localparam int HALFSC  = SCALE / 2;
	localparam int MAPSIZE = NAXES * ROWLEN;
	localparam int DRAIN_CYC = 80;        // well past the serial divide plus lookups
	localparam int HOLD_CYC  = 300;       // long receiver hold-off
	localparam int CYC_LIMIT = 600000;

	// one input transaction
	typedef struct {
		logic [1:0]         knd;
		logic [7:0]         code;
		logic signed [31:0] val;
		logic [3:0]         ax;
		logic [14:0]        ti;
		logic [14:0]        te;
		logic [7:0]         rx;
	} link_item_t;

	// one output transaction
	typedef struct {
		logic       fr;
		logic [7:0] tx;
		logic       lst;
		logic [2:0] st;
	} link_res_t;

	// directed row: expected values typed in only where chk is set
	typedef struct {
		link_item_t it;
		bit         chk;
		link_res_t  r0, r1, r2;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [9:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [7:0] action_code = '0;
	logic signed [31:0] action_value = '0;
	logic [3:0] table_axis = '0;
	logic [14:0] table_index = '0;
	logic [14:0] table_entry = '0;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_frame;
	logic [7:0] tx_byte;
	logic last;
	logic [2:0] reply_status;

	gamepad_action_frame_link_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .action_code(action_code), .action_value(action_value),
		.table_axis(table_axis), .table_index(table_index), .table_entry(table_entry),
		.rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_frame(is_frame), .tx_byte(tx_byte), .last(last), .reply_status(reply_status)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------- link predictor state ----------------
	logic [14:0] gmap [MAPSIZE];
	logic [7:0]  cmap [MAPSIZE];
	bit          gmap_wr [MAPSIZE];   // game entry written (and its target calib entry too)
	int          gpool [NAXES][$];    // written game indexes per axis
	int          cpool [NAXES][$];    // written calib positions per axis
	logic [9:0]  mouse_max_q = 10'd30;
	logic [7:0]  want_reply = 8'd1;
	logic [1:0]  rphase = 2'd0;       // 0 waiting, 1 after zero byte, 2 skipping
	logic [7:0]  skip_left = 8'd0;

	link_res_t frame_q [$];           // frame bytes and reply statuses still to arrive

	int mismatches = 0;
	int cyc = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int items_sent = 0;

	// relative motion: scale by mouse_max (0 acts as 1), recenter, clamp
	function automatic int rel_index(logic signed [31:0] v);
		longint d, x;
		d = (mouse_max_q == 0) ? 1 : longint'(mouse_max_q);
		x = (100 * longint'(v)) / d + HALFSC;
		if (x > SCALE) x = SCALE;
		if (x < 0) x = 0;
		return int'(x);
	endfunction

	function automatic logic [7:0] map_read(int a, int idx);
		int g;
		if (a >= NAXES) return 8'd0;
		if (idx > SCALE) idx = SCALE;
		g = gmap[a * ROWLEN + idx];
		if (g > SCALE) g = SCALE;
		return cmap[a * ROWLEN + g];
	endfunction

	function automatic link_res_t mk_res(logic fr, logic [7:0] tx, logic lst, logic [2:0] st);
		link_res_t r;
		r.fr = fr; r.tx = tx; r.lst = lst; r.st = st;
		return r;
	endfunction

	// advance the link state for one accepted transaction; queue results if asked
	function automatic void link_step(link_item_t it, bit queue_it);
		int base, idx, ax;
		logic [7:0] act, vb, b0, b2, sum;
		logic [2:0] st;
		longint v;
		if (it.knd == KIND_GAME || it.knd == KIND_CALIB) begin
			if (it.ax < NAXES && it.ti <= SCALE) begin
				base = it.ax * ROWLEN + it.ti;
				if (it.knd == KIND_GAME) begin
					gmap[base] = it.te;
					if (!gmap_wr[base]) gpool[it.ax].push_back(int'(it.ti));
					gmap_wr[base] = 1'b1;
				end else begin
					cmap[base] = it.te[7:0];
					cpool[it.ax].push_back(int'(it.ti));
				end
			end
			return;
		end
		if (it.knd == KIND_ACTION) begin
			act = it.code;
			if (it.code >= 10 && it.code < 50) begin
				act = it.code + 8'd10;
				vb = (it.val != 0) ? 8'd1 : 8'd0;
			end else if (it.code >= 50 && it.code < 60) begin
				ax = it.code - 50;
				act = 8'(ax);
				v = it.val;
				if (v > HALFSC) v = HALFSC;
				if (v < -HALFSC) v = -HALFSC;
				vb = map_read(ax, int'(v) + HALFSC);
			end else if (it.code >= 100 && it.code < 110) begin
				ax = it.code - 100;
				act = 8'(ax);
				vb = map_read(ax, rel_index(it.val));
			end else begin
				vb = it.val[7:0];
			end
			b0 = act + 8'd1;
			b2 = b0 ^ vb;
			sum = b0 + vb + b2;
			want_reply = (sum == 0) ? 8'd1 : sum;
			rphase = 2'd0;       // a new action restarts reply tracking
			skip_left = 8'd0;
			if (queue_it) begin
				frame_q.push_back(mk_res(1'b1, b0, 1'b0, ST_PENDING));
				frame_q.push_back(mk_res(1'b1, vb, 1'b0, ST_PENDING));
				frame_q.push_back(mk_res(1'b1, b2, 1'b1, ST_PENDING));
			end
			return;
		end
		st = ST_PENDING;
		if (rphase == 2'd1) begin
			if (it.rx == 0) begin
				st = ST_HEART;
				rphase = 2'd0;
			end else begin
				skip_left = it.rx;
				rphase = 2'd2;
			end
		end else if (rphase == 2'd2) begin
			if (skip_left > 0) skip_left--;
			if (skip_left == 0) begin
				st = ST_SKIPPED;
				rphase = 2'd0;
			end
		end else begin
			if (it.rx == want_reply) st = ST_MATCHED;
			else if (it.rx == 0) rphase = 2'd1;
			else st = ST_BROKEN;
		end
		if (queue_it) frame_q.push_back(mk_res(1'b0, 8'd0, 1'b1, st));
	endfunction

	// ---------------- stimulus builders ----------------
	function automatic link_item_t rand_fill();
		link_item_t it;
		it.knd = 2'($urandom_range(3));
		it.code = 8'($urandom_range(255));
		it.val = $urandom;
		it.ax = 4'($urandom_range(15));
		it.ti = 15'($urandom_range(32767));
		it.te = 15'($urandom_range(32767));
		it.rx = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic link_item_t act_item(logic [7:0] code, logic signed [31:0] val);
		link_item_t it;
		it = rand_fill();
		it.knd = KIND_ACTION; it.code = code; it.val = val;
		return it;
	endfunction

	function automatic link_item_t rx_item(logic [7:0] b);
		link_item_t it;
		it = rand_fill();
		it.knd = KIND_REPLY; it.rx = b;
		return it;
	endfunction

	function automatic link_item_t wr_item(logic [1:0] k, int a, int ti, int te);
		link_item_t it;
		it = rand_fill();
		it.knd = k; it.ax = 4'(a); it.ti = 15'(ti); it.te = 15'(te);
		return it;
	endfunction

	// absolute axis value landing on a written game index
	function automatic logic signed [31:0] abs_value(int a);
		int i;
		i = gpool[a][$urandom_range(gpool[a].size() - 1)];
		if (i == SCALE && $urandom_range(1)) return $urandom_range(32'h7fffffff, HALFSC);
		if (i == 0 && $urandom_range(1)) return 32'sh80000000 + $urandom_range(2147473647);
		return i - HALFSC;
	endfunction

	// relative motion value landing on a written game index, center as fallback
	function automatic logic signed [31:0] rel_value(int a);
		int i;
		longint d, v;
		logic signed [31:0] c;
		i = gpool[a][$urandom_range(gpool[a].size() - 1)];
		if (i == SCALE) return $urandom_range(32'h7fffffff, 32'h40000000);
		if (i == 0) return 32'sh80000000 + $urandom_range(32'h3fffffff);
		d = (mouse_max_q == 0) ? 1 : longint'(mouse_max_q);
		v = (longint'(i - HALFSC) * d) / 100;
		for (int k = -3; k <= 3; k++) begin
			c = 32'(v + k);
			if (gmap_wr[a * ROWLEN + rel_index(c)]) return c;
		end
		return 0;
	endfunction

	// game entry that points at a written calib position (or saturates onto one)
	function automatic int game_entry(int a);
		if ($urandom_range(7) == 0) return $urandom_range(32767, SCALE + 1);
		return cpool[a][$urandom_range(cpool[a].size() - 1)];
	endfunction

	// ---------------- drivers ----------------
	// offer one transaction; payload changes only at the falling edge
	task automatic send(link_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = it.knd;
		action_code = it.code;
		action_value = it.val;
		table_axis = it.ax;
		table_index = it.ti;
		table_entry = it.te;
		rx_byte = it.rx;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		link_step(it, 1'b1);
		items_sent++;
	endtask

	task automatic send_checked(dir_row_t row);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = row.it.knd;
		action_code = row.it.code;
		action_value = row.it.val;
		table_axis = row.it.ax;
		table_index = row.it.ti;
		table_entry = row.it.te;
		rx_byte = row.it.rx;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		link_step(row.it, 1'b0);
		if (row.it.knd == KIND_ACTION) begin
			frame_q.push_back(row.r0);
			frame_q.push_back(row.r1);
			frame_q.push_back(row.r2);
		end else if (row.it.knd == KIND_REPLY) begin
			frame_q.push_back(row.r0);
		end
	endtask

	// let everything owed come out, then cover map writes still in flight
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic set_mouse_max(logic [9:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		mouse_max_q = v;
	endtask

	// ---------------- receiver ----------------
	// hold-off is counted here; the main thread only bumps hold_req
	int hold_seen = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------- checker ----------------
	always @(posedge clk) begin
		link_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected transaction fr=%0d tx=%02h last=%0d st=%0d",
						is_frame, tx_byte, last, reply_status);
			end else begin
				e = frame_q.pop_front();
				if (is_frame !== e.fr || tx_byte !== e.tx || last !== e.lst
						|| reply_status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: exp fr=%0d tx=%02h last=%0d st=%0d, got fr=%0d tx=%02h last=%0d st=%0d",
							e.fr, e.tx, e.lst, e.st, is_frame, tx_byte, last, reply_status);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	// one action followed by a typical reply pattern, or a map write or noise
	task automatic rand_sequence();
		int r, n, a;
		logic [7:0] code;
		logic signed [31:0] v;
		r = $urandom_range(99);
		if (r < 10) begin
			// map rewrite keeping every lookup target written
			a = $urandom_range(NAXES - 1);
			if ($urandom_range(1))
				send(wr_item(KIND_CALIB, a, $urandom_range(SCALE), $urandom_range(32767)));
			else
				send(wr_item(KIND_GAME, a, $urandom_range(SCALE), game_entry(a)));
			return;
		end
		if (r < 14) begin
			// ignored write: axis or index out of range
			if ($urandom_range(1))
				send(wr_item(2'($urandom_range(2, 1)), $urandom_range(15, NAXES),
					$urandom_range(32767), $urandom_range(32767)));
			else
				send(wr_item(2'($urandom_range(2, 1)), $urandom_range(15),
					$urandom_range(32767, SCALE + 1), $urandom_range(32767)));
			return;
		end
		if (r < 20) begin
			send(rx_item(8'($urandom_range(255))));
			return;
		end
		case ($urandom_range(3))
			0: code = 8'($urandom_range(59, 50));
			1: code = 8'($urandom_range(109, 100));
			default: code = 8'($urandom_range(255));
		endcase
		if (code >= 50 && code < 60) v = abs_value(code - 50);
		else if (code >= 100 && code < 110) v = rel_value(code - 100);
		else v = ($urandom_range(3) == 0) ? 0 : $urandom;
		send(act_item(code, v));
		case ($urandom_range(5))
			0, 1: send(rx_item(want_reply));
			2: begin
				send(rx_item(8'd0));
				send(rx_item(8'd0));
			end
			3: begin
				n = ($urandom_range(15) == 0) ? $urandom_range(255, 9) : $urandom_range(8, 1);
				send(rx_item(8'd0));
				send(rx_item(8'(n)));
				repeat (n) send(rx_item(8'($urandom_range(255))));
			end
			4: send(rx_item(8'($urandom_range(255))));
			default: ;
		endcase
	endtask

	initial begin
		dir_row_t head_rows [$];
		dir_row_t tail_rows [$];
		dir_row_t row;
		link_res_t nz;
		int idle_set [5] = '{0, 77, 0, 38, 0};
		int stall_set [5] = '{0, 0, 77, 38, 0};
		logic [9:0] mm_set [5] = '{10'd30, 10'd1, 10'd1000, 10'd0, 10'd727};
		int pos;

		nz = mk_res(1'b0, 8'd0, 1'b0, ST_PENDING);

		// directed rows before any map is loaded; reply checks follow the link rules
		row.chk = 1'b1; row.r1 = nz; row.r2 = nz;
		row.it = rx_item(8'd1);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_MATCHED);
		head_rows.push_back(row);
		row.it = act_item(8'd0, 32'sh7fffffff);
		row.r0 = mk_res(1'b1, 8'h01, 1'b0, ST_PENDING);
		row.r1 = mk_res(1'b1, 8'hff, 1'b0, ST_PENDING);
		row.r2 = mk_res(1'b1, 8'hfe, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		// byte sum wraps to zero: expected reply becomes one
		row.it = act_item(8'd255, 32'sh80000000);
		row.r0 = mk_res(1'b1, 8'h00, 1'b0, ST_PENDING);
		row.r1 = mk_res(1'b1, 8'h00, 1'b0, ST_PENDING);
		row.r2 = mk_res(1'b1, 8'h00, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		row.it = rx_item(8'd1);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_MATCHED);
		head_rows.push_back(row);
		row.it = act_item(8'd10, -32'sd1);
		row.r0 = mk_res(1'b1, 8'h15, 1'b0, ST_PENDING);
		row.r1 = mk_res(1'b1, 8'h01, 1'b0, ST_PENDING);
		row.r2 = mk_res(1'b1, 8'h14, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		row.it = rx_item(8'd0);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		row.it = rx_item(8'd0);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_HEART);
		head_rows.push_back(row);
		row.it = act_item(8'd49, 32'sd0);
		row.r0 = mk_res(1'b1, 8'h3c, 1'b0, ST_PENDING);
		row.r1 = mk_res(1'b1, 8'h00, 1'b0, ST_PENDING);
		row.r2 = mk_res(1'b1, 8'h3c, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		row.it = rx_item(8'd0);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_PENDING);
		head_rows.push_back(row);
		row.it = rx_item(8'd2);       head_rows.push_back(row);
		row.it = rx_item(8'd7);       head_rows.push_back(row);
		row.it = rx_item(8'd9);       row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_SKIPPED);
		head_rows.push_back(row);
		row.it = rx_item(8'h55);      row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_BROKEN);
		head_rows.push_back(row);
		row.it = rx_item(8'h78);      row.r0 = mk_res(1'b0, 8'h00, 1'b1, ST_MATCHED);
		head_rows.push_back(row);
		// the rest come from the predictor
		row.chk = 1'b0;
		row.it = wr_item(KIND_GAME, 15, 5, 123);            head_rows.push_back(row);
		row.it = wr_item(KIND_CALIB, 3, 32767, 32767);      head_rows.push_back(row);
		row.it = wr_item(KIND_GAME, NAXES, SCALE + 1, 0);   head_rows.push_back(row);
		row.it = rx_item(8'd0);                             head_rows.push_back(row);
		// action mid-reply restarts tracking
		row.it = act_item(8'd60, 32'sh1234);                head_rows.push_back(row);
		row.it = act_item(8'd99, -32'sd2);                  head_rows.push_back(row);

		// lookups at the clamp edges and center, plus a code past the relative range, after map load
		row.it = act_item(8'd50, 32'sh7fffffff);  tail_rows.push_back(row);
		row.it = act_item(8'd59, 32'sh80000000);  tail_rows.push_back(row);
		row.it = act_item(8'd55, 32'sd0);         tail_rows.push_back(row);
		row.it = act_item(8'd100, 32'sh7fffffff); tail_rows.push_back(row);
		row.it = act_item(8'd109, 32'sh80000000); tail_rows.push_back(row);
		row.it = act_item(8'd104, 32'sd0);        tail_rows.push_back(row);
		row.it = act_item(8'd110, 32'sh5a5a5aa5); tail_rows.push_back(row);

		// hold reset, then release it at a falling edge
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (head_rows[i]) begin
			if (head_rows[i].chk) send_checked(head_rows[i]);
			else send(head_rows[i].it);
		end

		// preload: calib first (always covering center and ends), then game entries
		// pointing only at written calib positions (or saturating onto one)
		for (int a = 0; a < NAXES; a++) begin
			send(wr_item(KIND_CALIB, a, 0, $urandom_range(32767)));
			send(wr_item(KIND_CALIB, a, HALFSC, $urandom_range(32767)));
			send(wr_item(KIND_CALIB, a, SCALE, $urandom_range(32767)));
			repeat (2) send(wr_item(KIND_CALIB, a, $urandom_range(SCALE), $urandom_range(32767)));
			send(wr_item(KIND_GAME, a, 0, game_entry(a)));
			send(wr_item(KIND_GAME, a, HALFSC, game_entry(a)));
			send(wr_item(KIND_GAME, a, SCALE, game_entry(a)));
			repeat (2) begin
				pos = ($urandom_range(1)) ? $urandom_range(SCALE)
					: HALFSC + $urandom_range(600) - 300;
				send(wr_item(KIND_GAME, a, pos, game_entry(a)));
			end
		end

		foreach (tail_rows[i]) send(tail_rows[i].it);
		items_sent = 0;

		// random phases, each with an idle and stall mix and its own mouse_max
		for (int p = 0; p < 5; p++) begin
			if (p != 0) set_mouse_max(mm_set[p]);
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			while (items_sent < (p + 1) * 60) begin
				rand_sequence();
				// back-pressure: receiver holds off while input keeps coming
				if (p == 0 && items_sent >= 20 && hold_req == 0) hold_req++;
				if (p == 4 && items_sent >= 260 && hold_req == 1) hold_req++;
				// mid-phase pause until everything owed is out
				if (p == 3 && items_sent >= 200 && items_sent < 203) drain();
			end
		end

		drain();
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
